[hw/rtl/uvs_pkg.sv]
// ---------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the uv sphere vertex generator
// Field widths, register codes, cordic gain and arctangent table.
// ---------------------------------------------------------------------------
package uvs_pkg;

   localparam int IDX_W          = 11;
   localparam int RAD_W          = 16;
   localparam int POS_W          = 17;
   localparam int CSR_W          = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int MAX_SEGMENTS   = 1024;
   localparam int CORDIC_STEPS   = 28;
   localparam int XY_W           = 33;
   localparam int Z_W            = 34;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(256);
   localparam logic [IDX_W-1:0] LAT_RESET    = IDX_W'(16);
   localparam logic [IDX_W-1:0] LON_RESET    = IDX_W'(32);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RADIUS = 2'd0,
      REG_LAT    = 2'd1,
      REG_LON    = 2'd2
   } reg_index_type;

   // control carried alongside every pipeline stage
   typedef struct packed {
      logic valid;
      logic err;
   } ctl_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic signed [Z_W-1:0] atan_turn(input int step);
      logic signed [Z_W-1:0] v;
      unique case (step)
         0:  v = Z_W'(536870912);
         1:  v = Z_W'(316933406);
         2:  v = Z_W'(167458907);
         3:  v = Z_W'(85004756);
         4:  v = Z_W'(42667331);
         5:  v = Z_W'(21354465);
         6:  v = Z_W'(10679838);
         7:  v = Z_W'(5340245);
         8:  v = Z_W'(2670163);
         9:  v = Z_W'(1335087);
         10: v = Z_W'(667544);
         11: v = Z_W'(333772);
         12: v = Z_W'(166886);
         13: v = Z_W'(83443);
         14: v = Z_W'(41722);
         15: v = Z_W'(20861);
         16: v = Z_W'(10430);
         17: v = Z_W'(5215);
         18: v = Z_W'(2608);
         19: v = Z_W'(1304);
         20: v = Z_W'(652);
         21: v = Z_W'(326);
         22: v = Z_W'(163);
         23: v = Z_W'(81);
         24: v = Z_W'(41);
         25: v = Z_W'(20);
         26: v = Z_W'(10);
         27: v = Z_W'(5);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/uvs_div_cell.sv]
// ---------------------------------------------------------------------------
// uvs_div_cell: one restoring division step for both angles
// Shifts one numerator bit into the remainder and one quotient bit out.
// ---------------------------------------------------------------------------
module uvs_div_cell #(
   parameter int QB = 17,
   parameter int DW = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  uvs_pkg::ctl_type ctl_in,
   input  logic [DW-1:0]    div_t,
   input  logic [DW-1:0]    div_p,
   input  logic [DW-1:0]    rem_t_in,
   input  logic [QB-1:0]    low_t_in,
   input  logic [DW-1:0]    rem_p_in,
   input  logic [QB-1:0]    low_p_in,
   output uvs_pkg::ctl_type ctl_out,
   output logic [DW-1:0]    rem_t_out,
   output logic [QB-1:0]    low_t_out,
   output logic [DW-1:0]    rem_p_out,
   output logic [QB-1:0]    low_p_out
);
   import uvs_pkg::*;

   ctl_type       ctl_ff;
   logic [DW-1:0] rem_t_ff, rem_t_in_w, rem_p_ff, rem_p_in_w;
   logic [QB-1:0] low_t_ff, low_t_in_w, low_p_ff, low_p_in_w;
   logic [DW:0]   trial_t, trial_p;
   logic          q_t, q_p;

   // compare and subtract on both lanes
   always_comb begin
      trial_t    = {rem_t_in, low_t_in[QB-1]};
      trial_p    = {rem_p_in, low_p_in[QB-1]};
      q_t        = (trial_t >= {1'b0, div_t});
      q_p        = (trial_p >= {1'b0, div_p});
      rem_t_in_w = q_t ? DW'(trial_t - {1'b0, div_t}) : trial_t[DW-1:0];
      rem_p_in_w = q_p ? DW'(trial_p - {1'b0, div_p}) : trial_p[DW-1:0];
      low_t_in_w = {low_t_in[QB-2:0], q_t};
      low_p_in_w = {low_p_in[QB-2:0], q_p};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_t_ff <= rem_t_in_w;
         rem_p_ff <= rem_p_in_w;
         low_t_ff <= low_t_in_w;
         low_p_ff <= low_p_in_w;
      end
   end

   assign ctl_out   = ctl_ff;
   assign rem_t_out = rem_t_ff;
   assign low_t_out = low_t_ff;
   assign rem_p_out = rem_p_ff;
   assign low_p_out = low_p_ff;

endmodule

[hw/rtl/uvs_cordic_cell.sv]
// ---------------------------------------------------------------------------
// uvs_cordic_cell: one cordic rotation step for both angles
// Rotates the vector by +-atan(2^-STEP) toward a zero residual angle.
// ---------------------------------------------------------------------------
module uvs_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  uvs_pkg::ctl_type                 ctl_in,
   input  logic [1:0]                       flip_in,
   input  logic signed [uvs_pkg::XY_W-1:0]  x_in [2],
   input  logic signed [uvs_pkg::XY_W-1:0]  y_in [2],
   input  logic signed [uvs_pkg::Z_W-1:0]   z_in [2],
   output uvs_pkg::ctl_type                 ctl_out,
   output logic [1:0]                       flip_out,
   output logic signed [uvs_pkg::XY_W-1:0]  x_out [2],
   output logic signed [uvs_pkg::XY_W-1:0]  y_out [2],
   output logic signed [uvs_pkg::Z_W-1:0]   z_out [2]
);
   import uvs_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN = atan_turn(STEP);

   ctl_type               ctl_ff;
   logic [1:0]            flip_ff;
   logic signed [XY_W-1:0] x_ff [2];
   logic signed [XY_W-1:0] y_ff [2];
   logic signed [Z_W-1:0]  z_ff [2];
   logic signed [XY_W-1:0] x_in_w [2];
   logic signed [XY_W-1:0] y_in_w [2];
   logic signed [Z_W-1:0]  z_in_w [2];

   // rotation direction from the sign of the residual angle
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (!z_in[k][Z_W-1]) begin
            x_in_w[k] = x_in[k] - (y_in[k] >>> STEP);
            y_in_w[k] = y_in[k] + (x_in[k] >>> STEP);
            z_in_w[k] = z_in[k] - ATAN;
         end else begin
            x_in_w[k] = x_in[k] + (y_in[k] >>> STEP);
            y_in_w[k] = y_in[k] - (x_in[k] >>> STEP);
            z_in_w[k] = z_in[k] + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flip_ff <= flip_in;
         for (int k = 0; k < 2; k++) begin
            x_ff[k] <= x_in_w[k];
            y_ff[k] <= y_in_w[k];
            z_ff[k] <= z_in_w[k];
         end
      end
   end

   assign ctl_out  = ctl_ff;
   assign flip_out = flip_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;

endmodule

[hw/rtl/uvs_scale.sv]
// ---------------------------------------------------------------------------
// uvs_scale: sine and cosine rounding, radius products, final rounding
// Four registered stages from cordic vectors to signed Q8.8 positions.
// ---------------------------------------------------------------------------
module uvs_scale (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  uvs_pkg::ctl_type                 ctl_in,
   input  logic [1:0]                       flip_in,
   input  logic signed [uvs_pkg::XY_W-1:0]  x_in [2],
   input  logic signed [uvs_pkg::XY_W-1:0]  y_in [2],
   input  logic [uvs_pkg::RAD_W-1:0]        radius,
   output uvs_pkg::ctl_type                 ctl_out,
   output logic signed [uvs_pkg::POS_W-1:0] pos_x,
   output logic signed [uvs_pkg::POS_W-1:0] pos_y,
   output logic signed [uvs_pkg::POS_W-1:0] pos_z
);
   import uvs_pkg::*;

   // round half up to Q1.15 and saturate
   function automatic logic signed [15:0] to_q15(input logic signed [XY_W-1:0] v);
      logic signed [XY_W:0]   sum;
      logic signed [XY_W-15:0] r;
      sum = {v[XY_W-1], v} + (XY_W+1)'(16384);
      r   = sum[XY_W:15];
      if (r > (XY_W-14)'(32767)) begin
         return 16'sd32767;
      end else if (r < -(XY_W-14)'(32768)) begin
         return -16'sd32768;
      end
      return r[15:0];
   endfunction

   ctl_type              ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [15:0]   st_ff, ct_ff, sp_ff, cp_ff;
   logic signed [15:0]   sp2_ff, cp2_ff;
   logic signed [32:0]   rs_ff, ry_ff, ry3_ff;
   logic signed [48:0]   px_ff, pz_ff;
   logic signed [POS_W-1:0] x4_ff, y4_ff, z4_ff;
   logic signed [XY_W-1:0] xt_f, yt_f, xp_f, yp_f;
   logic signed [16:0]   r_s;
   logic signed [48:0]   px_r, pz_r;
   logic signed [32:0]   py_r;

   // undo the half-turn fold
   always_comb begin
      xt_f = flip_in[0] ? -x_in[0] : x_in[0];
      yt_f = flip_in[0] ? -y_in[0] : y_in[0];
      xp_f = flip_in[1] ? -x_in[1] : x_in[1];
      yp_f = flip_in[1] ? -y_in[1] : y_in[1];
      r_s  = {1'b0, radius};
      px_r = px_ff + 49'sd536870912;
      pz_r = pz_ff + 49'sd536870912;
      py_r = ry3_ff + 33'sd16384;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (en) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: Q1.15 sine and cosine
         st_ff  <= to_q15(yt_f);
         ct_ff  <= to_q15(xt_f);
         sp_ff  <= to_q15(yp_f);
         cp_ff  <= to_q15(xp_f);
         // stage 2: radius times sin(theta) and cos(theta)
         rs_ff  <= r_s * st_ff;
         ry_ff  <= r_s * ct_ff;
         sp2_ff <= sp_ff;
         cp2_ff <= cp_ff;
         // stage 3: times the azimuth terms
         px_ff  <= rs_ff * cp2_ff;
         pz_ff  <= rs_ff * sp2_ff;
         ry3_ff <= ry_ff;
         // stage 4: round, zero on error
         x4_ff  <= ctl3_ff.err ? '0 : px_r[30+POS_W-1:30];
         y4_ff  <= ctl3_ff.err ? '0 : py_r[15+POS_W-1:15];
         z4_ff  <= ctl3_ff.err ? '0 : pz_r[30+POS_W-1:30];
      end
   end

   assign ctl_out = ctl4_ff;
   assign pos_x   = x4_ff;
   assign pos_y   = y4_ff;
   assign pos_z   = z4_ff;

endmodule

[hw/rtl/uv_sphere_vertex_generator.sv]
// ---------------------------------------------------------------------------
// uv_sphere_vertex_generator: one uv sphere vertex per grid index
// Divider cells, cordic cells and a scaling pipeline with an output skid.
// ---------------------------------------------------------------------------
// Usage: the request channel (req_*) carries a latitude and longitude index,
// the response channel (rsp_*) returns the vertex position in signed Q8.8 and
// an index error flag in rsp_tuser. Radius and segment counts are written on
// the csr_* port while no request is in flight.
// Throughput: one request per clock while the skid register is empty. From
// acceptance to rsp_tvalid a request passes through ANGLE_BITS + 1 restoring
// division cells, 28 cordic cells, four scaling stages and the output
// register. Each cell does one step and hands its result on while the chain is enabled.
// Stall: when rsp_tready is low the pipeline keeps running until the skid
// register fills; then req_tready drops and the whole chain holds. A request
// is still accepted while a finished response waits in the output register.
// Reset: synchronous; clears all valid bits, loads radius 1.0, 16 latitude
// bands and 32 longitude slices. No clearing pass is needed.
// ---------------------------------------------------------------------------
module uv_sphere_vertex_generator #(
   parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // lat_index [10:0], lon_index [21:11]
   input  logic [23:0]                     req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // pos_x [16:0], pos_y [33:17], pos_z [50:34]
   output logic [55:0]                     rsp_tdata,
   // index_error [0]
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wen,
   input  logic [uvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uvs_pkg::CSR_W-1:0]       csr_wdata
);
   import uvs_pkg::*;

   localparam int QB = ANGLE_BITS + 1;
   localparam int DW = IDX_W + 1;
   localparam int NW = IDX_W + ANGLE_BITS + 2;

   // configuration registers
   logic [RAD_W-1:0] radius_ff;
   logic [IDX_W-1:0] lat_seg_ff, lon_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RADIUS_RESET;
         lat_seg_ff <= LAT_RESET;
         lon_seg_ff <= LON_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_RADIUS: radius_ff  <= csr_wdata;
            REG_LAT:    lat_seg_ff <= csr_wdata[IDX_W-1:0];
            REG_LON:    lon_seg_ff <= csr_wdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // chain enable and request admission
   logic en;
   logic skid_valid_ff, skid_valid_in;
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // request decode and division numerators
   logic [IDX_W-1:0] lat_idx, lon_idx;
   logic [NW-1:0]    num_t, num_p;
   logic [DW-1:0]    div_t, div_p;
   ctl_type          ctl0;

   always_comb begin
      lat_idx    = req_tdata[IDX_W-1:0];
      lon_idx    = req_tdata[2*IDX_W-1:IDX_W];
      num_t      = (NW'(lat_idx) << ANGLE_BITS) + NW'(lat_seg_ff);
      num_p      = (NW'(lon_idx) << (ANGLE_BITS + 1)) + NW'(lon_seg_ff);
      div_t      = {lat_seg_ff, 1'b0};
      div_p      = {lon_seg_ff, 1'b0};
      ctl0.valid = req_tvalid;
      ctl0.err   = (lat_seg_ff == '0) || (lon_seg_ff == '0) ||
                   (lat_seg_ff > IDX_W'(MAX_SEGMENTS)) ||
                   (lon_seg_ff > IDX_W'(MAX_SEGMENTS)) ||
                   (lat_idx > lat_seg_ff) || (lon_idx > lon_seg_ff);
   end

   // division cell chain
   ctl_type       dctl  [QB+1];
   logic [DW-1:0] rem_t [QB+1];
   logic [QB-1:0] low_t [QB+1];
   logic [DW-1:0] rem_p [QB+1];
   logic [QB-1:0] low_p [QB+1];

   assign dctl[0]  = ctl0;
   assign rem_t[0] = num_t[NW-1:QB];
   assign low_t[0] = num_t[QB-1:0];
   assign rem_p[0] = num_p[NW-1:QB];
   assign low_p[0] = num_p[QB-1:0];

   for (genvar g = 0; g < QB; g++) begin : g_div
      uvs_div_cell #(.QB(QB), .DW(DW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .ctl_in    (dctl[g]),
         .div_t     (div_t),
         .div_p     (div_p),
         .rem_t_in  (rem_t[g]),
         .low_t_in  (low_t[g]),
         .rem_p_in  (rem_p[g]),
         .low_p_in  (low_p[g]),
         .ctl_out   (dctl[g+1]),
         .rem_t_out (rem_t[g+1]),
         .low_t_out (low_t[g+1]),
         .rem_p_out (rem_p[g+1]),
         .low_p_out (low_p[g+1])
      );
   end

   // angle widening and half-turn fold into the cordic range
   logic [31:0] ang [2];
   logic [31:0] fold [2];
   ctl_type               cctl  [CORDIC_STEPS+1];
   logic [1:0]            cflip [CORDIC_STEPS+1];
   logic signed [XY_W-1:0] cx   [CORDIC_STEPS+1][2];
   logic signed [XY_W-1:0] cy   [CORDIC_STEPS+1][2];
   logic signed [Z_W-1:0]  cz   [CORDIC_STEPS+1][2];

   always_comb begin
      ang[0] = {low_t[QB][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
      ang[1] = {low_p[QB][ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
      for (int k = 0; k < 2; k++) begin
         cflip[0][k] = ang[k][31] ^ ang[k][30];
         fold[k]     = {ang[k][31] ^ cflip[0][k], ang[k][30:0]};
         cx[0][k]    = CORDIC_GAIN;
         cy[0][k]    = '0;
         cz[0][k]    = Z_W'($signed(fold[k]));
      end
   end

   assign cctl[0] = dctl[QB];

   // cordic cell chain
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      uvs_cordic_cell #(.STEP(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_in   (cctl[g]),
         .flip_in  (cflip[g]),
         .x_in     (cx[g]),
         .y_in     (cy[g]),
         .z_in     (cz[g]),
         .ctl_out  (cctl[g+1]),
         .flip_out (cflip[g+1]),
         .x_out    (cx[g+1]),
         .y_out    (cy[g+1]),
         .z_out    (cz[g+1])
      );
   end

   // scaling by the radius
   ctl_type                 sctl;
   logic signed [POS_W-1:0] sx, sy, sz;

   uvs_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (cctl[CORDIC_STEPS]),
      .flip_in (cflip[CORDIC_STEPS]),
      .x_in    (cx[CORDIC_STEPS]),
      .y_in    (cy[CORDIC_STEPS]),
      .radius  (radius_ff),
      .ctl_out (sctl),
      .pos_x   (sx),
      .pos_y   (sy),
      .pos_z   (sz)
   );

   // output register and skid stage
   logic [3*POS_W:0] last_data;
   logic [3*POS_W:0] rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;
   logic             rsp_valid_ff, rsp_valid_in, take;

   always_comb begin
      last_data     = {sctl.err, sz, sy, sx};
      take          = rsp_valid_ff && rsp_tready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (en && sctl.valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_in  = last_data;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = last_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff[3*POS_W-1:0]};
   assign rsp_tuser  = rsp_data_ff[3*POS_W];

endmodule
